[design/mqtt_packet_deframer_unit_assert.svh]
// Assertion macros shared by the MQTT deframer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef MQTT_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define MQTT_PACKET_DEFRAMER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Clocked check, held off while reset is asserted.
`define MPD_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("mqttpd: assertion failed");
// Clocked check that also holds during reset.
`define MPD_ASSERT_ALWAYS(lbl, ck, prop) \
    lbl: assert property (@(posedge ck) (prop)) \
        else $error("mqttpd: assertion failed");
`else
`define MPD_ASSERT(lbl, ck, rn, prop)
`define MPD_ASSERT_ALWAYS(lbl, ck, prop)
`endif

`endif

[design/mqttpd_pkg.sv]
// Types and constants for the MQTT 3.1.1 packet deframer.
// No dependencies; used by mqttpd_result_queue and mqtt_packet_deframer_unit.
package mqttpd_pkg;

    localparam int MAX_LENGTH_BYTES = 4;   // longest remaining-length varint
    localparam int QUEUE_DEPTH      = 4;   // result queue entries, at least 2

    localparam logic [3:0] TYPE_PUBLISH = 4'h3;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_TLEN_HI,
        PH_TLEN_LO,
        PH_TOPIC,
        PH_ID_HI,
        PH_ID_LO,
        PH_PAYLOAD,
        PH_SKIP,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TOPIC,
        KIND_PAYLOAD,
        KIND_END,
        KIND_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_VARINT,
        ERR_TOPIC
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [3:0]  packet_type;
        logic [3:0]  header_flags;
        logic [1:0]  qos_level;
        logic [15:0] packet_ident;
        logic        ack_needed;
        logic [15:0] topic_length;
        logic [27:0] payload_length;
        err_t        fault_code;
        logic        last;
    } result_t;

endpackage

[design/mqttpd_result_queue.sv]
// Result queue of the MQTT deframer: up to two pushes per cycle, one pop.
// Depends on mqttpd_pkg (result_t) and mqtt_packet_deframer_unit_assert.svh.
`include "mqtt_packet_deframer_unit_assert.svh"

module mqttpd_result_queue #(
    parameter int DEPTH = mqttpd_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_cnt,
    input  mqttpd_pkg::result_t push_data0,
    input  mqttpd_pkg::result_t push_data1,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output mqttpd_pkg::result_t out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    mqttpd_pkg::result_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_p1, wr_ptr_p2;
    logic          pop;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_p1 = wrap_inc(wr_ptr_reg);
    assign wr_ptr_p2 = wrap_inc(wr_ptr_p1);
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign room      = (count_reg <= CW'(DEPTH - 2));

    always_comb
    begin
        count_next  = count_reg + CW'(push_cnt) - CW'(pop);
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push_cnt)
            2'd0:    wr_ptr_next = wr_ptr_reg;
            2'd1:    wr_ptr_next = wr_ptr_p1;
            default: wr_ptr_next = wr_ptr_p2;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage carries no reset
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= push_data0;
        if (push_cnt == 2'd2)
            mem_reg[wr_ptr_p1] <= push_data1;
    end

    `MPD_ASSERT(a_queue_no_overflow, clk, rst_n, (push_cnt != 2'd0) |-> (int'(count_reg) + int'(push_cnt) <= DEPTH))
    `MPD_ASSERT(a_queue_pop_advances, clk, rst_n, (out_valid && out_ready && push_cnt == 2'd0) |=> (count_reg == $past(count_reg) - 1'b1))

endmodule

[design/mqtt_packet_deframer_unit.sv]
// Top level of the MQTT 3.1.1 packet deframer.
// Depends on mqttpd_pkg, mqttpd_result_queue and mqtt_packet_deframer_unit_assert.svh.
//
//  Channel  Dir  Handshake             Payload
//  -------  ---  --------------------  ----------------------------------------------
//  input    in   in_valid / in_ready   rx_byte, restart
//  result   out  out_valid / out_ready kind, data_byte, packet_type, header_flags,
//                                      qos_level, packet_ident, ack_needed,
//                                      topic_length, payload_length, fault_code, last
//
// One byte per cycle: the parser state is updated in the cycle a byte transfers, and
// its zero, one or two results land in the result queue at the same edge.
// A result reaches the output through the registered result queue, behind any results queued before it.
// in_ready is high while the queue holds QUEUE_DEPTH - 2 results or fewer; with out_ready
// held high a byte transfers every cycle, a stalled output holds the input once it fills.
// Reset (rst_n low, asynchronous) puts the parser at the fixed header and empties the
// queue; a byte transferred with restart high does the same for the parser only.
`include "mqtt_packet_deframer_unit_assert.svh"

module mqtt_packet_deframer_unit #(
    parameter int QUEUE_DEPTH = mqttpd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [3:0]  packet_type,
    output logic [3:0]  header_flags,
    output logic [1:0]  qos_level,
    output logic [15:0] packet_ident,
    output logic        ack_needed,
    output logic [15:0] topic_length,
    output logic [27:0] payload_length,
    output logic [1:0]  fault_code,
    output logic        last
);

    localparam logic [2:0] MAX_LEN_BYTES = 3'(mqttpd_pkg::MAX_LENGTH_BYTES);

    // parser state
    mqttpd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  header_reg, header_next;
    logic [27:0] remaining_reg, remaining_next;
    logic [1:0]  varint_idx_reg, varint_idx_next;
    logic [15:0] topic_len_reg, topic_len_next;
    logic [15:0] topic_left_reg, topic_left_next;
    logic [15:0] ident_reg, ident_next;
    logic [27:0] body_left_reg, body_left_next;

    logic        accept;
    logic        is_pub;
    logic [1:0]  qos;
    logic        qos_pos;
    logic [27:0] body_dec;
    logic [15:0] topic_dec;
    logic [27:0] len_addend;
    logic [27:0] len_sum;
    logic [15:0] tlen_lo;
    logic [16:0] topic_need;

    // what this byte produces
    logic              emit_data;
    mqttpd_pkg::kind_t data_kind;
    logic              emit_end;
    logic              emit_err;
    mqttpd_pkg::err_t  err_code;

    mqttpd_pkg::result_t res_data, res_end, res_err;
    mqttpd_pkg::result_t res0, res1;
    logic [1:0]          push_cnt;
    logic                room;
    mqttpd_pkg::result_t out_data;

    assign accept   = in_valid && in_ready;
    assign in_ready = room;

    assign is_pub  = (header_reg[7:4] == mqttpd_pkg::TYPE_PUBLISH);
    assign qos     = is_pub ? header_reg[2:1] : 2'd0;
    assign qos_pos = (qos != 2'd0);

    assign body_dec   = body_left_reg - 28'd1;
    assign topic_dec  = topic_left_reg - 16'd1;
    assign tlen_lo    = {topic_len_reg[15:8], rx_byte};
    assign topic_need = {1'b0, tlen_lo} + (qos_pos ? 17'd2 : 17'd0);
    assign len_sum    = remaining_reg + len_addend;

    // 7 bits per varint byte, least significant group first
    always_comb
    begin
        case (varint_idx_reg)
            2'd0:    len_addend = {21'd0, rx_byte[6:0]};
            2'd1:    len_addend = {14'd0, rx_byte[6:0], 7'd0};
            2'd2:    len_addend = {7'd0, rx_byte[6:0], 14'd0};
            default: len_addend = {rx_byte[6:0], 21'd0};
        endcase
    end

    // next state and the results of the current byte
    always_comb
    begin
        phase_next      = phase_reg;
        header_next     = header_reg;
        remaining_next  = remaining_reg;
        varint_idx_next = varint_idx_reg;
        topic_len_next  = topic_len_reg;
        topic_left_next = topic_left_reg;
        ident_next      = ident_reg;
        body_left_next  = body_left_reg;
        emit_data       = 1'b0;
        data_kind       = mqttpd_pkg::KIND_TOPIC;
        emit_end        = 1'b0;
        emit_err        = 1'b0;
        err_code        = mqttpd_pkg::ERR_NONE;

        if (restart)
        begin
            phase_next      = mqttpd_pkg::PH_HEADER;
            header_next     = '0;
            remaining_next  = '0;
            varint_idx_next = '0;
            topic_len_next  = '0;
            topic_left_next = '0;
            ident_next      = '0;
            body_left_next  = '0;
        end
        else
        begin
            case (phase_reg)
                mqttpd_pkg::PH_HEADER:
                begin
                    header_next     = rx_byte;
                    remaining_next  = '0;
                    varint_idx_next = '0;
                    topic_len_next  = '0;
                    topic_left_next = '0;
                    ident_next      = '0;
                    body_left_next  = '0;
                    phase_next      = mqttpd_pkg::PH_LENGTH;
                end
                mqttpd_pkg::PH_LENGTH:
                begin
                    remaining_next = len_sum;
                    if (rx_byte[7])
                    begin
                        if ({1'b0, varint_idx_reg} + 3'd1 >= MAX_LEN_BYTES)
                        begin
                            emit_err   = 1'b1;
                            err_code   = mqttpd_pkg::ERR_VARINT;
                            phase_next = mqttpd_pkg::PH_ERROR;
                        end
                        else
                            varint_idx_next = varint_idx_reg + 2'd1;
                    end
                    else
                    begin
                        body_left_next = len_sum;
                        if (is_pub)
                        begin
                            if (len_sum < 28'd2)
                            begin
                                // no room for the topic length field
                                emit_err   = 1'b1;
                                err_code   = mqttpd_pkg::ERR_TOPIC;
                                phase_next = mqttpd_pkg::PH_ERROR;
                            end
                            else
                                phase_next = mqttpd_pkg::PH_TLEN_HI;
                        end
                        else if (len_sum == 28'd0)
                            phase_next = mqttpd_pkg::PH_HEADER;
                        else
                            phase_next = mqttpd_pkg::PH_SKIP;
                    end
                end
                mqttpd_pkg::PH_TLEN_HI:
                begin
                    topic_len_next = {rx_byte, 8'd0};
                    body_left_next = body_dec;
                    phase_next     = mqttpd_pkg::PH_TLEN_LO;
                end
                mqttpd_pkg::PH_TLEN_LO:
                begin
                    topic_len_next = tlen_lo;
                    body_left_next = body_dec;
                    if ({11'd0, topic_need} > body_dec)
                    begin
                        emit_err   = 1'b1;
                        err_code   = mqttpd_pkg::ERR_TOPIC;
                        phase_next = mqttpd_pkg::PH_ERROR;
                    end
                    else
                    begin
                        topic_left_next = tlen_lo;
                        if (tlen_lo != 16'd0)
                            phase_next = mqttpd_pkg::PH_TOPIC;
                        else if (qos_pos)
                            phase_next = mqttpd_pkg::PH_ID_HI;
                        else if (body_dec == 28'd0)
                        begin
                            emit_end   = 1'b1;
                            phase_next = mqttpd_pkg::PH_HEADER;
                        end
                        else
                            phase_next = mqttpd_pkg::PH_PAYLOAD;
                    end
                end
                mqttpd_pkg::PH_TOPIC:
                begin
                    emit_data       = 1'b1;
                    data_kind       = mqttpd_pkg::KIND_TOPIC;
                    body_left_next  = body_dec;
                    topic_left_next = topic_dec;
                    if (topic_dec == 16'd0)
                    begin
                        if (qos_pos)
                            phase_next = mqttpd_pkg::PH_ID_HI;
                        else if (body_dec == 28'd0)
                        begin
                            emit_end   = 1'b1;
                            phase_next = mqttpd_pkg::PH_HEADER;
                        end
                        else
                            phase_next = mqttpd_pkg::PH_PAYLOAD;
                    end
                end
                mqttpd_pkg::PH_ID_HI:
                begin
                    ident_next     = {rx_byte, 8'd0};
                    body_left_next = body_dec;
                    phase_next     = mqttpd_pkg::PH_ID_LO;
                end
                mqttpd_pkg::PH_ID_LO:
                begin
                    ident_next     = {ident_reg[15:8], rx_byte};
                    body_left_next = body_dec;
                    if (body_dec == 28'd0)
                    begin
                        emit_end   = 1'b1;
                        phase_next = mqttpd_pkg::PH_HEADER;
                    end
                    else
                        phase_next = mqttpd_pkg::PH_PAYLOAD;
                end
                mqttpd_pkg::PH_PAYLOAD:
                begin
                    emit_data      = 1'b1;
                    data_kind      = mqttpd_pkg::KIND_PAYLOAD;
                    body_left_next = body_dec;
                    if (body_dec == 28'd0)
                    begin
                        emit_end   = 1'b1;
                        phase_next = mqttpd_pkg::PH_HEADER;
                    end
                end
                mqttpd_pkg::PH_SKIP:
                begin
                    // body of a packet we do not decode
                    if (body_left_reg != 28'd0)
                        body_left_next = body_dec;
                    if (body_left_reg <= 28'd1)
                        phase_next = mqttpd_pkg::PH_HEADER;
                end
                default:
                    phase_next = mqttpd_pkg::PH_ERROR;
            endcase
        end
    end

    // result items; header fields come from the current header byte, which
    // never changes on a byte that produces a result
    always_comb
    begin
        res_data                = '0;
        res_data.kind           = data_kind;
        res_data.data_byte      = rx_byte;
        res_data.packet_type    = header_reg[7:4];
        res_data.header_flags   = header_reg[3:0];
        res_data.qos_level      = qos;

        res_end                 = '0;
        res_end.kind            = mqttpd_pkg::KIND_END;
        res_end.packet_type     = header_reg[7:4];
        res_end.header_flags    = header_reg[3:0];
        res_end.qos_level       = qos;
        res_end.packet_ident    = qos_pos ? ident_next : 16'd0;
        res_end.ack_needed      = (qos == 2'd1);
        res_end.topic_length    = topic_len_next;
        res_end.payload_length  = remaining_reg - 28'd2 - {12'd0, topic_len_next}
                                  - (qos_pos ? 28'd2 : 28'd0);

        res_err                 = '0;
        res_err.kind            = mqttpd_pkg::KIND_ERROR;
        res_err.packet_type     = header_reg[7:4];
        res_err.header_flags    = header_reg[3:0];
        res_err.qos_level       = qos;
        res_err.fault_code      = err_code;

        res0     = res_data;
        res1     = res_end;
        push_cnt = 2'd0;
        if (accept)
        begin
            if (emit_data && emit_end)
            begin
                push_cnt = 2'd2;
                res1.last = 1'b1;
            end
            else if (emit_data)
            begin
                push_cnt = 2'd1;
                res0.last = 1'b1;
            end
            else if (emit_end)
            begin
                push_cnt  = 2'd1;
                res0      = res_end;
                res0.last = 1'b1;
            end
            else if (emit_err)
            begin
                push_cnt  = 2'd1;
                res0      = res_err;
                res0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= mqttpd_pkg::PH_HEADER;
            header_reg     <= '0;
            remaining_reg  <= '0;
            varint_idx_reg <= '0;
            topic_len_reg  <= '0;
            topic_left_reg <= '0;
            ident_reg      <= '0;
            body_left_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            header_reg     <= header_next;
            remaining_reg  <= remaining_next;
            varint_idx_reg <= varint_idx_next;
            topic_len_reg  <= topic_len_next;
            topic_left_reg <= topic_left_next;
            ident_reg      <= ident_next;
            body_left_reg  <= body_left_next;
        end
    end

    mqttpd_result_queue #(
        .DEPTH      (QUEUE_DEPTH)
    ) u_result_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_data0 (res0),
        .push_data1 (res1),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign kind           = out_data.kind;
    assign data_byte      = out_data.data_byte;
    assign packet_type    = out_data.packet_type;
    assign header_flags   = out_data.header_flags;
    assign qos_level      = out_data.qos_level;
    assign packet_ident   = out_data.packet_ident;
    assign ack_needed     = out_data.ack_needed;
    assign topic_length   = out_data.topic_length;
    assign payload_length = out_data.payload_length;
    assign fault_code     = out_data.fault_code;
    assign last           = out_data.last;

    `MPD_ASSERT(a_restart_to_header, clk, rst_n, (accept && restart) |=> (phase_reg == mqttpd_pkg::PH_HEADER))
    `MPD_ASSERT(a_error_is_silent, clk, rst_n, (phase_reg == mqttpd_pkg::PH_ERROR) |-> (push_cnt == 2'd0))
    `MPD_ASSERT(a_pair_ends_packet, clk, rst_n, (push_cnt == 2'd2) |-> (res1.kind == mqttpd_pkg::KIND_END && phase_next == mqttpd_pkg::PH_HEADER))
    `MPD_ASSERT_ALWAYS(a_no_push_without_room, clk, (push_cnt != 2'd0) |-> room)

endmodule

[bench/tb.sv]
// Self-checking testbench for mqtt_packet_deframer_unit: a directed byte table, then
// random MQTT packet streams, checked result by result against a local parser model.
// Depends on mqttpd_pkg and the deframer RTL.
`timescale 1ns / 100ps

module tb;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_BYTES = 700;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [7:0]        b;
        logic              rs;
        logic              typed;   // kind and fault code of the last result are given here
        mqttpd_pkg::kind_t k;
        mqttpd_pkg::err_t  e;
    } dir_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = 8'h00;
    logic        restart   = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [3:0]  packet_type;
    logic [3:0]  header_flags;
    logic [1:0]  qos_level;
    logic [15:0] packet_ident;
    logic        ack_needed;
    logic [15:0] topic_length;
    logic [27:0] payload_length;
    logic [1:0]  fault_code;
    logic        last;

    // Table values ride along with the byte they belong to.
    logic              row_typed = 1'b0;
    mqttpd_pkg::kind_t row_kind  = mqttpd_pkg::KIND_TOPIC;
    mqttpd_pkg::err_t  row_err   = mqttpd_pkg::ERR_NONE;

    logic burst = 1'b0;        // no idling on either side while set
    int   mismatches   = 0;
    int   results_seen = 0;
    int   bytes_parsed = 0;    // transfers not swallowed by the error phase

    // Parser model state
    mqttpd_pkg::phase_t prs_phase = mqttpd_pkg::PH_HEADER;
    logic [7:0]  prs_hdr   = 8'h00;
    logic [27:0] prs_rem   = 28'd0;
    logic [1:0]  prs_idx   = 2'd0;
    logic [15:0] prs_tlen  = 16'd0;
    logic [15:0] prs_tleft = 16'd0;
    logic [15:0] prs_id    = 16'd0;
    logic [27:0] prs_body  = 28'd0;

    mqttpd_pkg::result_t step_out [2];
    int                  step_n;
    mqttpd_pkg::result_t pending_results [$];
    logic [7:0]          pkt_bytes [$];

    dir_row_t directed_rows [0:28] = '{
        // PINGREQ, zero body: consumed with no result
        '{8'hC0, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        // PUBLISH QoS 3, empty topic, id 0xffff, empty payload
        '{8'h3F, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h04, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b1, mqttpd_pkg::KIND_END,   mqttpd_pkg::ERR_NONE},
        // PUBLISH QoS 1, one topic byte, no payload: end item carries the ack
        '{8'h32, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h05, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h01, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h12, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h34, 1'b0, 1'b1, mqttpd_pkg::KIND_END,   mqttpd_pkg::ERR_NONE},
        // remaining length with a continuation bit on every byte
        '{8'h30, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h80, 1'b0, 1'b1, mqttpd_pkg::KIND_ERROR, mqttpd_pkg::ERR_VARINT},
        '{8'hFF, 1'b1, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        // PUBLISH body too short for the topic length
        '{8'h30, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h01, 1'b0, 1'b1, mqttpd_pkg::KIND_ERROR, mqttpd_pkg::ERR_TOPIC},
        '{8'h00, 1'b1, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        // topic plus packet id overruns the body
        '{8'h32, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h03, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE},
        '{8'h02, 1'b0, 1'b1, mqttpd_pkg::KIND_ERROR, mqttpd_pkg::ERR_TOPIC},
        '{8'hA5, 1'b1, 1'b0, mqttpd_pkg::KIND_TOPIC, mqttpd_pkg::ERR_NONE}
    };

    mqtt_packet_deframer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .packet_type    (packet_type),
        .header_flags   (header_flags),
        .qos_level      (qos_level),
        .packet_ident   (packet_ident),
        .ack_needed     (ack_needed),
        .topic_length   (topic_length),
        .payload_length (payload_length),
        .fault_code     (fault_code),
        .last           (last)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ---------------------------------------------------------------- parser model

    function automatic logic [1:0] cur_qos();
        return (prs_hdr[7:4] == mqttpd_pkg::TYPE_PUBLISH) ? prs_hdr[2:1] : 2'd0;
    endfunction

    task automatic emit_result(input mqttpd_pkg::kind_t k, input logic [7:0] d,
                               input mqttpd_pkg::err_t e);
        mqttpd_pkg::result_t r;
        logic [1:0]          q;
        q = cur_qos();
        r = '0;
        r.kind         = k;
        r.data_byte    = (k == mqttpd_pkg::KIND_TOPIC || k == mqttpd_pkg::KIND_PAYLOAD)
                         ? d : 8'h00;
        r.packet_type  = prs_hdr[7:4];
        r.header_flags = prs_hdr[3:0];
        r.qos_level    = q;
        if (k == mqttpd_pkg::KIND_END)
        begin
            r.packet_ident   = (q != 2'd0) ? prs_id : 16'd0;
            r.ack_needed     = (q == 2'd1);
            r.topic_length   = prs_tlen;
            // wraps at 28 bits like the length field itself
            r.payload_length = prs_rem - 28'd2 - 28'(prs_tlen)
                               - ((q != 2'd0) ? 28'd2 : 28'd0);
        end
        if (k == mqttpd_pkg::KIND_ERROR)
            r.fault_code = e;
        step_out[step_n] = r;
        step_n++;
    endtask

    task automatic raise_error(input mqttpd_pkg::err_t e);
        prs_phase = mqttpd_pkg::PH_ERROR;
        emit_result(mqttpd_pkg::KIND_ERROR, 8'h00, e);
    endtask

    task automatic to_payload();
        if (prs_body == 28'd0)
        begin
            emit_result(mqttpd_pkg::KIND_END, 8'h00, mqttpd_pkg::ERR_NONE);
            prs_phase = mqttpd_pkg::PH_HEADER;
        end
        else
            prs_phase = mqttpd_pkg::PH_PAYLOAD;
    endtask

    task automatic after_topic();
        if (cur_qos() != 2'd0)
            prs_phase = mqttpd_pkg::PH_ID_HI;
        else
            to_payload();
    endtask

    // One byte transfer: updates the model and leaves its results in step_out.
    task automatic parse_byte(input logic [7:0] b, input logic rs);
        int unsigned need;
        step_n = 0;
        if (rs)
        begin
            prs_phase = mqttpd_pkg::PH_HEADER;
            prs_hdr   = 8'h00;
            prs_rem   = 28'd0;
            prs_idx   = 2'd0;
            prs_tlen  = 16'd0;
            prs_tleft = 16'd0;
            prs_id    = 16'd0;
            prs_body  = 28'd0;
        end
        else
        begin
            case (prs_phase)
                mqttpd_pkg::PH_HEADER:
                begin
                    prs_hdr   = b;
                    prs_rem   = 28'd0;
                    prs_idx   = 2'd0;
                    prs_tlen  = 16'd0;
                    prs_tleft = 16'd0;
                    prs_id    = 16'd0;
                    prs_body  = 28'd0;
                    prs_phase = mqttpd_pkg::PH_LENGTH;
                end
                mqttpd_pkg::PH_LENGTH:
                begin
                    prs_rem = prs_rem + (28'(b[6:0]) << (7 * prs_idx));
                    if (b[7])
                    begin
                        if (int'(prs_idx) + 1 >= mqttpd_pkg::MAX_LENGTH_BYTES)
                            raise_error(mqttpd_pkg::ERR_VARINT);
                        else
                            prs_idx = prs_idx + 2'd1;
                    end
                    else
                    begin
                        prs_body = prs_rem;
                        if (prs_hdr[7:4] == mqttpd_pkg::TYPE_PUBLISH)
                        begin
                            if (prs_body < 28'd2)
                                raise_error(mqttpd_pkg::ERR_TOPIC);
                            else
                                prs_phase = mqttpd_pkg::PH_TLEN_HI;
                        end
                        else
                            prs_phase = (prs_body == 28'd0) ? mqttpd_pkg::PH_HEADER
                                                            : mqttpd_pkg::PH_SKIP;
                    end
                end
                mqttpd_pkg::PH_TLEN_HI:
                begin
                    prs_tlen  = {b, 8'h00};
                    prs_body  = prs_body - 28'd1;
                    prs_phase = mqttpd_pkg::PH_TLEN_LO;
                end
                mqttpd_pkg::PH_TLEN_LO:
                begin
                    prs_tlen[7:0] = b;
                    prs_body      = prs_body - 28'd1;
                    need = prs_tlen + ((cur_qos() != 2'd0) ? 2 : 0);
                    if (need > prs_body)
                        raise_error(mqttpd_pkg::ERR_TOPIC);
                    else
                    begin
                        prs_tleft = prs_tlen;
                        if (prs_tleft != 16'd0)
                            prs_phase = mqttpd_pkg::PH_TOPIC;
                        else
                            after_topic();
                    end
                end
                mqttpd_pkg::PH_TOPIC:
                begin
                    emit_result(mqttpd_pkg::KIND_TOPIC, b, mqttpd_pkg::ERR_NONE);
                    prs_body  = prs_body - 28'd1;
                    prs_tleft = prs_tleft - 16'd1;
                    if (prs_tleft == 16'd0)
                        after_topic();
                end
                mqttpd_pkg::PH_ID_HI:
                begin
                    prs_id    = {b, 8'h00};
                    prs_body  = prs_body - 28'd1;
                    prs_phase = mqttpd_pkg::PH_ID_LO;
                end
                mqttpd_pkg::PH_ID_LO:
                begin
                    prs_id[7:0] = b;
                    prs_body    = prs_body - 28'd1;
                    to_payload();
                end
                mqttpd_pkg::PH_PAYLOAD:
                begin
                    emit_result(mqttpd_pkg::KIND_PAYLOAD, b, mqttpd_pkg::ERR_NONE);
                    prs_body = prs_body - 28'd1;
                    to_payload();
                end
                mqttpd_pkg::PH_SKIP:
                begin
                    if (prs_body != 28'd0)
                        prs_body = prs_body - 28'd1;
                    if (prs_body == 28'd0)
                        prs_phase = mqttpd_pkg::PH_HEADER;
                end
                default:
                    prs_phase = mqttpd_pkg::PH_ERROR;   // discard until restart
            endcase
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR t=%0t: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : scoreboard
        mqttpd_pkg::result_t got;
        mqttpd_pkg::result_t want;
        mqttpd_pkg::result_t r;
        string               diffs;
        int                  i;
        if (rst_n)
        begin
            // predict first: a byte's results never show up in its own cycle
            if (in_valid && in_ready)
            begin
                if (restart || prs_phase != mqttpd_pkg::PH_ERROR)
                    bytes_parsed++;
                parse_byte(rx_byte, restart);
                if (row_typed && step_n == 0)
                    report_mismatch("directed row typed a result the parser never makes");
                for (i = 0; i < step_n; i++)
                begin
                    r      = step_out[i];
                    r.last = (i == step_n - 1);
                    if (r.last && row_typed)
                    begin
                        r.kind       = row_kind;
                        r.fault_code = row_err;
                    end
                    pending_results.push_back(r);
                end
            end
            if (out_valid && out_ready)
            begin
                got.kind           = mqttpd_pkg::kind_t'(kind);
                got.data_byte      = data_byte;
                got.packet_type    = packet_type;
                got.header_flags   = header_flags;
                got.qos_level      = qos_level;
                got.packet_ident   = packet_ident;
                got.ack_needed     = ack_needed;
                got.topic_length   = topic_length;
                got.payload_length = payload_length;
                got.fault_code     = mqttpd_pkg::err_t'(fault_code);
                got.last           = last;
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result %0d with nothing pending: %h",
                                              results_seen, got));
                else
                begin
                    want  = pending_results.pop_front();
                    diffs = "";
                    if (got.kind !== want.kind)                   diffs = {diffs, " kind"};
                    if (got.data_byte !== want.data_byte)         diffs = {diffs, " data"};
                    if (got.packet_type !== want.packet_type)     diffs = {diffs, " type"};
                    if (got.header_flags !== want.header_flags)   diffs = {diffs, " flags"};
                    if (got.qos_level !== want.qos_level)         diffs = {diffs, " qos"};
                    if (got.packet_ident !== want.packet_ident)   diffs = {diffs, " ident"};
                    if (got.ack_needed !== want.ack_needed)       diffs = {diffs, " ack"};
                    if (got.topic_length !== want.topic_length)   diffs = {diffs, " tlen"};
                    if (got.payload_length !== want.payload_length)
                        diffs = {diffs, " plen"};
                    if (got.fault_code !== want.fault_code)       diffs = {diffs, " err"};
                    if (got.last !== want.last)                   diffs = {diffs, " last"};
                    if (diffs != "")
                        report_mismatch($sformatf("result %0d:%s got %h want %h",
                                                  results_seen, diffs, got, want));
                end
                results_seen++;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic int pick_wait();
        return burst ? 0 : $urandom_range(0, 3);
    endfunction

    // Holds valid and payload steady until the transfer happens.
    task automatic send_byte(input logic [7:0] b, input logic rs);
        int gap;
        gap = pick_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        restart  <= rs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_packet();
        int j;
        for (j = 0; j < pkt_bytes.size(); j++)
            send_byte(pkt_bytes[j], 1'b0);
        pkt_bytes.delete();
    endtask

    // Varint, padded with zero groups up to n_req bytes when asked.
    task automatic add_length(input int unsigned v, input int n_req);
        int          n;
        int          m;
        int          i;
        int unsigned t;
        m = 1;
        t = v >> 7;
        while (t != 0)
        begin
            m++;
            t = t >> 7;
        end
        n = (n_req > m) ? n_req : m;
        for (i = 0; i < n; i++)
        begin
            pkt_bytes.push_back({(i < n - 1), 7'(v)});
            v = v >> 7;
        end
    endtask

    task automatic add_random(input int n);
        int i;
        for (i = 0; i < n; i++)
            pkt_bytes.push_back(8'($urandom));
    endtask

    initial
    begin : result_sink
        int w;
        wait (rst_n);
        forever
        begin
            w = pick_wait();
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int   sel;
        int   qos;
        int   tl;
        int   pl;
        int   rem;
        int   n;
        int   i;
        logic big;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < $size(directed_rows); i++)
        begin
            row_typed <= directed_rows[i].typed;
            row_kind  <= directed_rows[i].k;
            row_err   <= directed_rows[i].e;
            send_byte(directed_rows[i].b, directed_rows[i].rs);
        end
        row_typed <= 1'b0;

        while (bytes_parsed < RANDOM_BYTES + $size(directed_rows))
        begin
            burst = ($urandom_range(0, 4) == 0);
            sel   = $urandom_range(0, 99);
            if (sel < 65)
            begin
                // well-formed PUBLISH, mostly short
                qos = $urandom_range(0, 3);
                big = ($urandom_range(0, 39) == 0);
                tl  = big ? $urandom_range(0, 300) : $urandom_range(0, 6);
                pl  = big ? $urandom_range(0, 200) : $urandom_range(0, 8);
                rem = 2 + tl + ((qos != 0) ? 2 : 0) + pl;
                pkt_bytes.push_back({mqttpd_pkg::TYPE_PUBLISH, 1'($urandom), 2'(qos),
                                     1'($urandom)});
                add_length(rem, $urandom_range(1, mqttpd_pkg::MAX_LENGTH_BYTES));
                pkt_bytes.push_back(8'(tl >> 8));
                pkt_bytes.push_back(8'(tl));
                add_random(tl);
                if (qos != 0)
                    add_random(2);
                add_random(pl);
                send_packet();
            end
            else if (sel < 80)
            begin
                // any other type: body skipped silently
                n = $urandom_range(0, 14);
                if (n >= mqttpd_pkg::TYPE_PUBLISH)
                    n++;
                pkt_bytes.push_back({4'(n), 4'($urandom)});
                pl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200)
                                                 : $urandom_range(0, 10);
                add_length(pl, $urandom_range(1, mqttpd_pkg::MAX_LENGTH_BYTES));
                add_random(pl);
                send_packet();
            end
            else if (sel < 88)
            begin
                // arbitrary header and length, cut short by restart
                n = $urandom_range(1, mqttpd_pkg::MAX_LENGTH_BYTES);
                pkt_bytes.push_back(8'($urandom));
                rem = $urandom_range(0, (1 << (7 * n)) - 1);
                add_length(rem, n);
                add_random($urandom_range(0, 12));
                send_packet();
                send_byte(8'($urandom), 1'b1);
            end
            else if (sel < 96)
            begin
                // mostly malformed packets; trailing bytes of those land in the error phase
                case ($urandom_range(0, 2))
                    0:
                    begin
                        pkt_bytes.push_back(8'($urandom));
                        for (i = 0; i < mqttpd_pkg::MAX_LENGTH_BYTES; i++)
                            pkt_bytes.push_back({1'b1, 7'($urandom)});
                    end
                    1:
                    begin
                        pkt_bytes.push_back({mqttpd_pkg::TYPE_PUBLISH, 4'($urandom)});
                        add_length($urandom_range(0, 1),
                                   $urandom_range(1, mqttpd_pkg::MAX_LENGTH_BYTES));
                    end
                    default:
                    begin
                        qos = $urandom_range(0, 3);
                        rem = 2 + $urandom_range(0, 6);
                        tl  = rem - 2 - ((qos != 0) ? 2 : 0) + 1 + $urandom_range(0, 2);
                        if (tl < 0)
                            tl = 0;
                        if ($urandom_range(0, 3) == 0)
                            tl = $urandom_range(0, 65535);
                        pkt_bytes.push_back({mqttpd_pkg::TYPE_PUBLISH, 1'($urandom),
                                             2'(qos), 1'($urandom)});
                        add_length(rem, $urandom_range(1, mqttpd_pkg::MAX_LENGTH_BYTES));
                        pkt_bytes.push_back(8'(tl >> 8));
                        pkt_bytes.push_back(8'(tl));
                    end
                endcase
                add_random($urandom_range(0, 4));
                send_packet();
                send_byte(8'($urandom), 1'b1);
            end
            else
            begin
                // raw noise with scattered restarts
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
                send_byte(8'($urandom), 1'b1);
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("mqtt_packet_deframer_unit: match");
        else
            $display("mqtt_packet_deframer_unit: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("mqtt_packet_deframer_unit: mismatch");
        $finish;
    end

endmodule

[mqtt_packet_deframer_unit.f]
+incdir+design
design/mqttpd_pkg.sv
design/mqttpd_result_queue.sv
design/mqtt_packet_deframer_unit.sv
bench/tb.sv
